// ===== sv/svv_pkg.sv =====
`default_nettype none

package svv_pkg;

   // Field widths fixed by the interface.
   localparam int CHAR_BITS    = 8;
   localparam int LENGTH_BITS  = 8;
   localparam int VERSION_BITS = 32;
   localparam int COUNT_BITS   = 9;

   // Default width of the parsed numbers.
   localparam int NUMBER_BITS_DEFAULT = 32;

   // Length limit after reset.
   localparam logic [LENGTH_BITS-1:0] LENGTH_RESET = 8'd95;

   // Character codes the parser looks for.
   localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 8'h39;
   localparam logic [CHAR_BITS-1:0] CHAR_UP_A  = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_UP_Z  = 8'h5a;
   localparam logic [CHAR_BITS-1:0] CHAR_LOW_A = 8'h61;
   localparam logic [CHAR_BITS-1:0] CHAR_LOW_Z = 8'h7a;
   localparam logic [CHAR_BITS-1:0] CHAR_DOT   = 8'h2e;
   localparam logic [CHAR_BITS-1:0] CHAR_DASH  = 8'h2d;
   localparam logic [CHAR_BITS-1:0] CHAR_PLUS  = 8'h2b;

   typedef logic [VERSION_BITS-1:0] version_type;

   // Result of one string, handed from the parser to the output register.
   typedef struct packed {
      logic        valid_res;
      logic        stable;
      version_type major_version;
      version_type minor_version;
      version_type patch_version;
   } result_type;

endpackage

`default_nettype wire

// ===== sv/svv_parser.sv =====
`default_nettype none

module svv_parser #(
   parameter int NUMBER_BITS = svv_pkg::NUMBER_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              step_en,
   input  wire logic [svv_pkg::CHAR_BITS-1:0]     char_code,
   input  wire logic                              is_terminator,
   input  wire logic [svv_pkg::LENGTH_BITS-1:0]   max_length,
   output svv_pkg::result_type                    result
);

   localparam int PROD_BITS = NUMBER_BITS + 4;

   typedef enum logic [2:0] {
      PH_MAJOR,
      PH_MINOR,
      PH_PATCH,
      PH_PRE,
      PH_BUILD
   } phase_type;

   phase_type                         phase_ff, phase_in;
   logic                              failed_ff, failed_in;
   logic [NUMBER_BITS-1:0]            acc_ff, acc_in;
   logic                              digit_seen_ff, digit_seen_in;
   logic                              lead_zero_ff, lead_zero_in;
   logic [NUMBER_BITS-1:0]            major_ff, major_in;
   logic [NUMBER_BITS-1:0]            minor_ff, minor_in;
   logic                              id_nonempty_ff, id_nonempty_in;
   logic                              id_all_digits_ff, id_all_digits_in;
   logic                              id_multi_ff, id_multi_in;
   logic                              has_pre_ff, has_pre_in;
   logic [svv_pkg::COUNT_BITS-1:0]    count_ff, count_in;

   logic                              is_digit;
   logic                              is_ident;
   logic [PROD_BITS-1:0]              acc_next;
   logic                              overflow;
   logic                              ident_ok;
   logic                              length_ok;
   logic                              phase_ok;
   logic                              ok;

   // Character classes.
   assign is_digit = (char_code >= svv_pkg::CHAR_ZERO) && (char_code <= svv_pkg::CHAR_NINE);
   assign is_ident = is_digit
                  || ((char_code >= svv_pkg::CHAR_UP_A) && (char_code <= svv_pkg::CHAR_UP_Z))
                  || ((char_code >= svv_pkg::CHAR_LOW_A) && (char_code <= svv_pkg::CHAR_LOW_Z))
                  || (char_code == svv_pkg::CHAR_DASH);

   // Accumulator times ten plus the new digit, as two shifts and adds.
   assign acc_next = {1'b0, acc_ff, 3'b000}
                   + {3'b000, acc_ff, 1'b0}
                   + PROD_BITS'(char_code[3:0]);
   assign overflow = (acc_next[PROD_BITS-1:NUMBER_BITS] != '0);

   // A numeric prerelease identifier longer than one character may not start with zero.
   assign ident_ok = id_nonempty_ff
                  && !((phase_ff == PH_PRE) && id_all_digits_ff && id_multi_ff && lead_zero_ff);

   // Next state for one word.
   always_comb begin
      phase_in         = phase_ff;
      failed_in        = failed_ff;
      acc_in           = acc_ff;
      digit_seen_in    = digit_seen_ff;
      lead_zero_in     = lead_zero_ff;
      major_in         = major_ff;
      minor_in         = minor_ff;
      id_nonempty_in   = id_nonempty_ff;
      id_all_digits_in = id_all_digits_ff;
      id_multi_in      = id_multi_ff;
      has_pre_in       = has_pre_ff;
      count_in         = count_ff;

      if (step_en && is_terminator) begin
         // The string is finished: start over.
         phase_in         = PH_MAJOR;
         failed_in        = 1'b0;
         acc_in           = '0;
         digit_seen_in    = 1'b0;
         lead_zero_in     = 1'b0;
         major_in         = '0;
         minor_in         = '0;
         id_nonempty_in   = 1'b0;
         id_all_digits_in = 1'b1;
         id_multi_in      = 1'b0;
         has_pre_in       = 1'b0;
         count_in         = '0;
      end else if (step_en) begin
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
         if (!failed_ff) begin
            unique case (phase_ff)
               PH_MAJOR, PH_MINOR, PH_PATCH: begin
                  // Numeric field.
                  if (is_digit) begin
                     if ((digit_seen_ff && lead_zero_ff) || overflow) begin
                        failed_in = 1'b1;
                     end else begin
                        acc_in        = acc_next[NUMBER_BITS-1:0];
                        digit_seen_in = 1'b1;
                        if (!digit_seen_ff && (char_code == svv_pkg::CHAR_ZERO)) begin
                           lead_zero_in = 1'b1;
                        end
                     end
                  end else if (!digit_seen_ff) begin
                     failed_in = 1'b1;
                  end else if ((char_code == svv_pkg::CHAR_DOT) && (phase_ff == PH_MAJOR)) begin
                     major_in      = acc_ff;
                     acc_in        = '0;
                     digit_seen_in = 1'b0;
                     lead_zero_in  = 1'b0;
                     phase_in      = PH_MINOR;
                  end else if ((char_code == svv_pkg::CHAR_DOT) && (phase_ff == PH_MINOR)) begin
                     minor_in      = acc_ff;
                     acc_in        = '0;
                     digit_seen_in = 1'b0;
                     lead_zero_in  = 1'b0;
                     phase_in      = PH_PATCH;
                  end else if ((char_code == svv_pkg::CHAR_DASH) && (phase_ff == PH_PATCH)) begin
                     has_pre_in       = 1'b1;
                     lead_zero_in     = 1'b0;
                     id_nonempty_in   = 1'b0;
                     id_all_digits_in = 1'b1;
                     id_multi_in      = 1'b0;
                     phase_in         = PH_PRE;
                  end else if ((char_code == svv_pkg::CHAR_PLUS) && (phase_ff == PH_PATCH)) begin
                     lead_zero_in     = 1'b0;
                     id_nonempty_in   = 1'b0;
                     id_all_digits_in = 1'b1;
                     id_multi_in      = 1'b0;
                     phase_in         = PH_BUILD;
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               PH_PRE, PH_BUILD: begin
                  // Dot-separated identifiers.
                  if (is_ident) begin
                     if (!id_nonempty_ff) begin
                        lead_zero_in = (char_code == svv_pkg::CHAR_ZERO);
                     end else begin
                        id_multi_in = 1'b1;
                     end
                     if (!is_digit) begin
                        id_all_digits_in = 1'b0;
                     end
                     id_nonempty_in = 1'b1;
                  end else if ((char_code == svv_pkg::CHAR_DOT)
                            || ((char_code == svv_pkg::CHAR_PLUS) && (phase_ff == PH_PRE))) begin
                     if (!ident_ok) begin
                        failed_in = 1'b1;
                     end else begin
                        id_nonempty_in   = 1'b0;
                        id_all_digits_in = 1'b1;
                        id_multi_in      = 1'b0;
                        lead_zero_in     = 1'b0;
                        if (char_code == svv_pkg::CHAR_PLUS) begin
                           phase_in = PH_BUILD;
                        end
                     end
                  end else begin
                     failed_in = 1'b1;
                  end
               end
               default: begin
                  failed_in = 1'b1;
               end
            endcase
         end
      end
   end

   // Verdict for a terminator arriving now.
   assign length_ok = (count_ff != '0)
                   && (count_ff <= {1'b0, max_length});

   always_comb begin
      unique case (phase_ff)
         PH_PATCH:         phase_ok = digit_seen_ff;
         PH_PRE, PH_BUILD: phase_ok = ident_ok;
         default:          phase_ok = 1'b0;
      endcase
   end

   assign ok = !failed_ff && length_ok && phase_ok;

   assign result.valid_res     = ok;
   assign result.stable        = ok && !has_pre_ff;
   assign result.major_version = ok ? svv_pkg::version_type'(major_ff) : '0;
   assign result.minor_version = ok ? svv_pkg::version_type'(minor_ff) : '0;
   assign result.patch_version = ok ? svv_pkg::version_type'(acc_ff) : '0;

   // Parser state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_MAJOR;
         failed_ff        <= 1'b0;
         acc_ff           <= '0;
         digit_seen_ff    <= 1'b0;
         lead_zero_ff     <= 1'b0;
         major_ff         <= '0;
         minor_ff         <= '0;
         id_nonempty_ff   <= 1'b0;
         id_all_digits_ff <= 1'b1;
         id_multi_ff      <= 1'b0;
         has_pre_ff       <= 1'b0;
         count_ff         <= '0;
      end else begin
         phase_ff         <= phase_in;
         failed_ff        <= failed_in;
         acc_ff           <= acc_in;
         digit_seen_ff    <= digit_seen_in;
         lead_zero_ff     <= lead_zero_in;
         major_ff         <= major_in;
         minor_ff         <= minor_in;
         id_nonempty_ff   <= id_nonempty_in;
         id_all_digits_ff <= id_all_digits_in;
         id_multi_ff      <= id_multi_in;
         has_pre_ff       <= has_pre_in;
         count_ff         <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/semver_string_validator.sv =====
// Semantic version string checker.
// Words arrive on the req_ channel (valid/ready), one ASCII character per
// word, and a word with req_is_terminator high closes the string. For each
// terminator one word leaves on the rsp_ channel: rsp_valid_res, rsp_stable
// and the major, minor and patch numbers (all zero for an invalid string).
// Character words produce no output.
// The length limit is written through csr_write_enable/csr_write_data; the user
// must do so only while the block is idle (not enforced); it is 95 after reset.
// A word accepted into the input register is parsed when it advances from there;
// the result of a terminator is registered in the output register as it is
// parsed and is then presented on rsp_ until the receiver takes it.
// Throughput: one word per cycle while no terminator is blocked, set by the single
// parse stage that updates the parser state whenever a word advances.
// If the receiver holds rsp_ready low, the result waits in the output
// register; character words keep flowing, and only a following terminator
// waits in the input register, which then drops req_ready.
// Reset is synchronous and active high; it empties both registers, clears
// the parser state and restores the length limit.
`default_nettype none

module semver_string_validator #(
   parameter int NUMBER_BITS = svv_pkg::NUMBER_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [svv_pkg::CHAR_BITS-1:0]     req_char_code,
   input  wire logic                              req_is_terminator,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic                                   rsp_valid_res,
   output logic                                   rsp_stable,
   output logic [svv_pkg::VERSION_BITS-1:0]       rsp_major_version,
   output logic [svv_pkg::VERSION_BITS-1:0]       rsp_minor_version,
   output logic [svv_pkg::VERSION_BITS-1:0]       rsp_patch_version,
   input  wire logic                              csr_write_enable,
   input  wire logic [svv_pkg::LENGTH_BITS-1:0]   csr_write_data
);

   logic                              in_valid_ff, in_valid_in;
   logic [svv_pkg::CHAR_BITS-1:0]     in_char_ff;
   logic                              in_term_ff;
   logic                              rsp_valid_ff, rsp_valid_in;
   svv_pkg::result_type               rsp_data_ff;
   logic [svv_pkg::LENGTH_BITS-1:0]   max_length_ff;
   logic                              advance;
   logic                              load_word;
   svv_pkg::result_type               result;

   // A character always moves on; a terminator needs room in the output register.
   assign advance   = in_valid_ff && (!in_term_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign load_word = req_valid && req_ready;

   assign in_valid_in  = load_word || (in_valid_ff && !advance);
   assign rsp_valid_in = (advance && in_term_ff) || (rsp_valid_ff && !rsp_ready);

   svv_parser #(
      .NUMBER_BITS (NUMBER_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step_en       (advance),
      .char_code     (in_char_ff),
      .is_terminator (in_term_ff),
      .max_length    (max_length_ff),
      .result        (result)
   );

   // Control registers and the length limit.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         max_length_ff <= svv_pkg::LENGTH_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            max_length_ff <= csr_write_data;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (load_word) begin
         in_char_ff <= req_char_code;
         in_term_ff <= req_is_terminator;
      end
      if (advance && in_term_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_valid_res     = rsp_data_ff.valid_res;
   assign rsp_stable        = rsp_data_ff.stable;
   assign rsp_major_version = rsp_data_ff.major_version;
   assign rsp_minor_version = rsp_data_ff.minor_version;
   assign rsp_patch_version = rsp_data_ff.patch_version;

`ifndef NO_ASSERTIONS
   // A stable version is always a valid one.
   a_stable_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_data_ff.stable || rsp_data_ff.valid_res))
      else $error("stable result reported for an invalid string");

   // An invalid string reports all numbers as zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.valid_res) |->
         ((rsp_data_ff.major_version == '0) && (rsp_data_ff.minor_version == '0)
          && (rsp_data_ff.patch_version == '0)))
      else $error("invalid result carries nonzero numbers");

   // A result appears only after a terminator was parsed.
   a_result_from_term: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff && in_term_ff))
      else $error("result produced without a terminator");

   // Back-pressure comes only from a held input word.
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && in_term_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked terminator");
`endif

endmodule

`default_nettype wire

// ===== tb/semver_string_validator_test.sv =====
`default_nettype none

module semver_string_validator_test;

   localparam int CYCLE_LIMIT      = 400000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int COUNT_LIMIT      = (1 << svv_pkg::COUNT_BITS) - 1;
   localparam int SETTLE_CYCLES    = 4;

   // Parser position within the version string.
   typedef enum logic [2:0] {
      STAGE_MAJOR,
      STAGE_MINOR,
      STAGE_PATCH,
      STAGE_PRERELEASE,
      STAGE_BUILD
   } parse_stage_type;

   // One input word, with an optional hand-typed result for terminators.
   typedef struct packed {
      logic [svv_pkg::CHAR_BITS-1:0] code;
      logic                          term;
      logic                          known;
      svv_pkg::result_type           res;
   } req_word_type;

   // One directed string: text, an optional raw byte in the middle, more text.
   typedef struct {
      string                         head;
      bit                            raw_on;
      logic [svv_pkg::CHAR_BITS-1:0] raw;
      string                         tail;
      bit                            known;
      svv_pkg::result_type           res;
   } row_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [svv_pkg::CHAR_BITS-1:0]    req_char_code = '0;
   logic                             req_is_terminator = 1'b0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic                             rsp_valid_res;
   logic                             rsp_stable;
   logic [svv_pkg::VERSION_BITS-1:0] rsp_major_version;
   logic [svv_pkg::VERSION_BITS-1:0] rsp_minor_version;
   logic [svv_pkg::VERSION_BITS-1:0] rsp_patch_version;
   logic                             csr_write_enable = 1'b0;
   logic [svv_pkg::LENGTH_BITS-1:0]  csr_write_data = '0;

   semver_string_validator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_char_code(req_char_code),
      .req_is_terminator(req_is_terminator),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_valid_res(rsp_valid_res),
      .rsp_stable(rsp_stable),
      .rsp_major_version(rsp_major_version),
      .rsp_minor_version(rsp_minor_version),
      .rsp_patch_version(rsp_patch_version),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parser state mirrored by the testbench.
   logic [svv_pkg::LENGTH_BITS-1:0]  length_limit;
   parse_stage_type                  parse_stage;
   bit                               parse_failed;
   logic [svv_pkg::VERSION_BITS-1:0] number_acc;
   bit                               number_started;
   bit                               starts_zero;
   logic [svv_pkg::VERSION_BITS-1:0] major_hold;
   logic [svv_pkg::VERSION_BITS-1:0] minor_hold;
   bit                               ident_open;
   bit                               ident_numeric;
   bit                               ident_long;
   bit                               saw_prerelease;
   int                               char_total;

   req_word_type                     word_q[$];
   svv_pkg::result_type              expected_q[$];
   row_type                          dir_rows[$];
   logic [svv_pkg::CHAR_BITS-1:0]    spell[$];
   string                            ident_pool = "0123456789ABCXYZabcxyz-";
   string                            noise_pool = "0123456789..--++aZz";

   int                               error_count = 0;
   int                               cycle_count = 0;
   int                               burst_left = 0;
   int                               gap_left = 0;
   bit                               hold_off_request = 1'b0;
   int                               hold_off_left = 0;
   int                               stall_step = 0;
   logic [31:0]                      stall_pattern = '1;

   function automatic bit is_decimal(input logic [svv_pkg::CHAR_BITS-1:0] c);
      return c >= svv_pkg::CHAR_ZERO && c <= svv_pkg::CHAR_NINE;
   endfunction

   function automatic bit is_ident_char(input logic [svv_pkg::CHAR_BITS-1:0] c);
      return is_decimal(c) || (c >= svv_pkg::CHAR_UP_A && c <= svv_pkg::CHAR_UP_Z) ||
             (c >= svv_pkg::CHAR_LOW_A && c <= svv_pkg::CHAR_LOW_Z) ||
             c == svv_pkg::CHAR_DASH;
   endfunction

   // An identifier may close only if it is non-empty; in the prerelease a
   // numeric identifier longer than one digit may not start with zero.
   function automatic bit ident_acceptable();
      if (!ident_open) return 1'b0;
      if (parse_stage == STAGE_PRERELEASE && ident_numeric && ident_long && starts_zero)
         return 1'b0;
      return 1'b1;
   endfunction

   task automatic clear_ident();
      ident_open = 1'b0;
      ident_numeric = 1'b1;
      ident_long = 1'b0;
      starts_zero = 1'b0;
   endtask

   task automatic clear_parse();
      parse_stage = STAGE_MAJOR;
      parse_failed = 1'b0;
      number_acc = '0;
      number_started = 1'b0;
      major_hold = '0;
      minor_hold = '0;
      clear_ident();
      saw_prerelease = 1'b0;
      char_total = 0;
   endtask

   // One character of the major, minor or patch number.
   task automatic parse_number_char(input logic [svv_pkg::CHAR_BITS-1:0] c);
      logic [63:0] grown;
      if (is_decimal(c)) begin
         if (number_started && starts_zero) begin
            parse_failed = 1'b1;
         end else begin
            grown = 64'(number_acc) * 64'd10 + 64'(c - svv_pkg::CHAR_ZERO);
            if (grown > 64'hFFFF_FFFF) begin
               parse_failed = 1'b1;
            end else begin
               number_acc = grown[svv_pkg::VERSION_BITS-1:0];
               if (!number_started && c == svv_pkg::CHAR_ZERO) starts_zero = 1'b1;
               number_started = 1'b1;
            end
         end
      end else if (!number_started) begin
         parse_failed = 1'b1;
      end else if (c == svv_pkg::CHAR_DOT && parse_stage != STAGE_PATCH) begin
         if (parse_stage == STAGE_MAJOR) major_hold = number_acc;
         else minor_hold = number_acc;
         parse_stage = (parse_stage == STAGE_MAJOR) ? STAGE_MINOR : STAGE_PATCH;
         number_acc = '0;
         number_started = 1'b0;
         starts_zero = 1'b0;
      end else if (parse_stage == STAGE_PATCH &&
                   (c == svv_pkg::CHAR_DASH || c == svv_pkg::CHAR_PLUS)) begin
         // The patch value stays in the accumulator from here on.
         saw_prerelease = (c == svv_pkg::CHAR_DASH);
         parse_stage = (c == svv_pkg::CHAR_DASH) ? STAGE_PRERELEASE : STAGE_BUILD;
         clear_ident();
      end else begin
         parse_failed = 1'b1;
      end
   endtask

   // One character of a prerelease or build identifier list.
   task automatic parse_ident_char(input logic [svv_pkg::CHAR_BITS-1:0] c);
      if (is_ident_char(c)) begin
         if (!ident_open) starts_zero = (c == svv_pkg::CHAR_ZERO);
         else ident_long = 1'b1;
         if (!is_decimal(c)) ident_numeric = 1'b0;
         ident_open = 1'b1;
      end else if (c == svv_pkg::CHAR_DOT ||
                   (c == svv_pkg::CHAR_PLUS && parse_stage == STAGE_PRERELEASE)) begin
         if (!ident_acceptable()) begin
            parse_failed = 1'b1;
         end else begin
            if (c == svv_pkg::CHAR_PLUS) parse_stage = STAGE_BUILD;
            clear_ident();
         end
      end else begin
         parse_failed = 1'b1;
      end
   endtask

   // Advances the mirrored parser by one accepted word. A terminator closes
   // the string and queues the expected result.
   task automatic parse_word(input req_word_type w);
      svv_pkg::result_type outcome;
      bit                  ok;
      if (!w.term) begin
         if (char_total < COUNT_LIMIT) char_total++;
         if (!parse_failed) begin
            if (parse_stage <= STAGE_PATCH) parse_number_char(w.code);
            else parse_ident_char(w.code);
         end
      end else begin
         ok = !parse_failed && char_total != 0 && char_total <= int'(length_limit);
         if (ok) begin
            case (parse_stage)
               STAGE_MAJOR, STAGE_MINOR: ok = 1'b0;
               STAGE_PATCH: ok = number_started;
               default: ok = ident_acceptable();
            endcase
         end
         outcome = '0;
         if (ok) begin
            outcome.valid_res = 1'b1;
            outcome.stable = !saw_prerelease;
            outcome.major_version = major_hold;
            outcome.minor_version = minor_hold;
            outcome.patch_version = number_acc;
         end
         expected_q.push_back(w.known ? w.res : outcome);
         clear_parse();
      end
   endtask

   function automatic svv_pkg::result_type version_result(input logic stable_bit,
                                                          input svv_pkg::version_type a, b, c);
      svv_pkg::result_type r;
      r.valid_res = 1'b1;
      r.stable = stable_bit;
      r.major_version = a;
      r.minor_version = b;
      r.patch_version = c;
      return r;
   endfunction

   task automatic push_char(input logic [svv_pkg::CHAR_BITS-1:0] c);
      req_word_type w;
      w = '0;
      w.code = c;
      word_q.push_back(w);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i]);
   endtask

   // The character code of a terminator is ignored, so it is random.
   task automatic push_end(input bit known, input svv_pkg::result_type res);
      req_word_type w;
      w.code = 8'($urandom_range(0, 255));
      w.term = 1'b1;
      w.known = known;
      w.res = res;
      word_q.push_back(w);
   endtask

   task automatic table_row(input string head, input bit raw_on,
                            input logic [svv_pkg::CHAR_BITS-1:0] raw, input string tail,
                            input bit known, input svv_pkg::result_type res);
      row_type r;
      r.head = head;
      r.raw_on = raw_on;
      r.raw = raw;
      r.tail = tail;
      r.known = known;
      r.res = res;
      dir_rows.push_back(r);
   endtask

   task automatic add_row(input string text, input bit known,
                          input svv_pkg::result_type res);
      table_row(text, 1'b0, 8'h00, "", known, res);
   endtask

   // Directed strings; rows with an obvious result carry it typed in.
   task automatic load_directed();
      string               pad;
      svv_pkg::result_type invalid;
      invalid = '0;
      pad = "";
      repeat (89) pad = {pad, "a"};
      dir_rows.delete();
      add_row("", 1'b1, invalid);
      add_row("0.0.0", 1'b1, version_result(1'b1, 0, 0, 0));
      add_row("4294967295.4294967295.4294967295", 1'b1,
              version_result(1'b1, '1, '1, '1));
      add_row("4294967296.0.0", 1'b1, invalid);
      add_row("01.2.3", 1'b1, invalid);
      add_row("1.2", 1'b1, invalid);
      add_row("1..3", 1'b1, invalid);
      add_row("1.2.3.4", 1'b1, invalid);
      add_row("V1.2.3", 1'b1, invalid);
      add_row("1.2.3-alpha.1+build.007", 1'b0, invalid);
      add_row("1.2.3-0.01", 1'b0, invalid);
      add_row("1.2.3-01a", 1'b0, invalid);
      add_row("1.2.3-0", 1'b0, invalid);
      add_row("1.2.3+001", 1'b0, invalid);
      add_row("1.2.3-", 1'b0, invalid);
      add_row("1.2.3+", 1'b0, invalid);
      add_row("1.2.3-a..b", 1'b0, invalid);
      add_row("1.2.3+a+b", 1'b0, invalid);
      add_row("1.2.3-x-y-.--+Z-z.9", 1'b0, invalid);
      add_row("10.20.30-beta+exp.sha.5114f85", 1'b0, invalid);
      // A NUL in the middle of the numbers and a high code in a prerelease.
      table_row("1.2.", 1'b1, 8'h00, "3", 1'b1, invalid);
      table_row("1.0.0-a", 1'b1, 8'hFF, "", 1'b1, invalid);
      // Exactly at the length limit of 95, then one character over it.
      add_row({"1.2.3+", pad}, 1'b1, version_result(1'b1, 1, 2, 3));
      add_row({"1.2.3+", pad, "a"}, 1'b1, invalid);

      // Walk the table into the stimulus queue.
      foreach (dir_rows[i]) begin
         push_text(dir_rows[i].head);
         if (dir_rows[i].raw_on) push_char(dir_rows[i].raw);
         push_text(dir_rows[i].tail);
         push_end(dir_rows[i].known, dir_rows[i].res);
      end
   endtask

   function automatic logic [svv_pkg::CHAR_BITS-1:0] noise_char();
      if ($urandom_range(0, 1) == 0) return 8'($urandom_range(0, 255));
      return noise_pool[$urandom_range(0, noise_pool.len() - 1)];
   endfunction

   task automatic spell_text(input string s);
      for (int i = 0; i < s.len(); i++) spell.push_back(s[i]);
   endtask

   // A number: mostly small, sometimes around the 32-bit limit or with a
   // leading zero.
   task automatic spell_number();
      logic [63:0] value;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: value = 64'($urandom_range(0, 99));
         5: value = 64'd0;
         6: value = 64'($urandom());
         7: value = 64'hFFFF_FFFF + 64'($urandom_range(0, 2)) - 64'd1;
         8: value = 64'd10000000000 + 64'($urandom());
         default: begin
            spell.push_back(svv_pkg::CHAR_ZERO);
            value = 64'($urandom_range(0, 999));
         end
      endcase
      spell_text($sformatf("%0d", value));
   endtask

   // A dot-separated list of identifiers, now and then with an empty one.
   task automatic spell_idents();
      int count;
      int len;
      bit numeric;
      count = $urandom_range(1, 3);
      for (int n = 0; n < count; n++) begin
         if (n != 0) spell.push_back(svv_pkg::CHAR_DOT);
         len = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 5);
         numeric = ($urandom_range(0, 2) == 0);
         for (int k = 0; k < len; k++) begin
            if (numeric) spell.push_back(svv_pkg::CHAR_ZERO + 8'($urandom_range(0, 9)));
            else spell.push_back(ident_pool[$urandom_range(0, ident_pool.len() - 1)]);
         end
      end
   endtask

   // Mostly well-formed versions with random content; a quarter of them get
   // one damaged spot, and a few strings are pure noise.
   task automatic build_spelling();
      int pick;
      int pos;
      spell.delete();
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         repeat ($urandom_range(0, 10)) spell.push_back(noise_char());
      end else begin
         spell_number();
         spell.push_back(svv_pkg::CHAR_DOT);
         spell_number();
         spell.push_back(svv_pkg::CHAR_DOT);
         spell_number();
         if ($urandom_range(0, 1) == 0) begin
            spell.push_back(svv_pkg::CHAR_DASH);
            spell_idents();
         end
         if ($urandom_range(0, 2) == 0) begin
            spell.push_back(svv_pkg::CHAR_PLUS);
            spell_idents();
         end
         if (pick >= 75) begin
            pos = $urandom_range(0, spell.size() - 1);
            case ($urandom_range(0, 3))
               0: spell[pos] = noise_char();
               1: spell.delete(pos);
               2: spell.insert(pos, noise_char());
               default: begin
                  while (spell.size() > pos) void'(spell.pop_back());
               end
            endcase
         end
      end
   endtask

   task automatic queue_random(input int char_budget);
      int                  pushed;
      svv_pkg::result_type none;
      none = '0;
      pushed = 0;
      while (pushed < char_budget) begin
         build_spelling();
         foreach (spell[i]) push_char(spell[i]);
         pushed += spell.size();
         push_end(1'b0, none);
      end
   endtask

   // Offers the queued words in bursts with random gaps in between.
   task automatic send_words();
      bit           accepted;
      req_word_type w;
      while (word_q.size() != 0) begin
         @(posedge clock);
         accepted = req_valid && req_ready;
         if (accepted) begin
            w = word_q.pop_front();
            parse_word(w);
         end
         if (!req_valid || accepted) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (word_q.size() != 0) begin
               req_valid <= 1'b1;
               req_char_code <= word_q[0].code;
               req_is_terminator <= word_q[0].term;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   endtask

   // Waits for every expected result, then lets the block settle.
   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_length(input logic [svv_pkg::LENGTH_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      length_limit = value;
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
   endtask

   task automatic check_result();
      svv_pkg::result_type want;
      if (expected_q.size() == 0) begin
         error_count++;
         $display("%0t: result expected none, got valid_res %0b stable %0b %0h.%0h.%0h",
                  $time, rsp_valid_res, rsp_stable, rsp_major_version,
                  rsp_minor_version, rsp_patch_version);
      end else begin
         want = expected_q.pop_front();
         compare_field("valid_res", 32'(want.valid_res), 32'(rsp_valid_res));
         compare_field("stable", 32'(want.stable), 32'(rsp_stable));
         compare_field("major_version", want.major_version, rsp_major_version);
         compare_field("minor_version", want.minor_version, rsp_minor_version);
         compare_field("patch_version", want.patch_version, rsp_patch_version);
      end
   endtask

   // Receiver: checks each accepted result word and stalls on a random
   // 32-bit ready pattern, sometimes fully open, and once for a long stretch.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) check_result();
         if (hold_off_left != 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else if (hold_off_request) begin
            hold_off_request = 1'b0;
            hold_off_left = LONG_HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            stall_step++;
            if (stall_step % 32 == 0) begin
               case ($urandom_range(0, 2))
                  0: stall_pattern = '1;
                  1: stall_pattern = $urandom() | $urandom();
                  default: stall_pattern = $urandom();
               endcase
            end
            rsp_ready <= stall_pattern[stall_step % 32];
         end
      end
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      length_limit = svv_pkg::LENGTH_RESET;
      clear_parse();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed strings at the reset length limit.
      load_directed();
      send_words();
      drain();

      // Widest limit, with the receiver holding off long enough to fill the block.
      write_length(8'd255);
      hold_off_request = 1'b1;
      queue_random(80);
      send_words();
      drain();

      // Narrowest limit: every string is rejected.
      write_length(8'd1);
      queue_random(20);
      send_words();
      drain();

      // A random short limit, so that many strings run over it.
      write_length(8'($urandom_range(2, 40)));
      queue_random(30);
      send_words();
      drain();

      // Widest limit again.
      write_length(8'd255);
      queue_random(50);
      send_words();
      drain();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
sv/svv_pkg.sv
sv/svv_parser.sv
sv/semver_string_validator.sv
tb/semver_string_validator_test.sv
